### hdl/rmt_pkg.sv
package rmt_pkg;

  // tree shape
  localparam int LEAVES     = 1024;
  localparam int VALUE_BITS = 32;
  localparam int NODES      = 2 * LEAVES;
  localparam int NODE_W     = $clog2(NODES);          // node index width
  localparam int R_W        = NODE_W + 1;             // right bound may reach NODES
  localparam int POS_W      = 10;                     // position field width
  localparam int VAL_PORT_W = 32;                     // value field width
  localparam int WIDE_W     = (R_W > POS_W) ? R_W : POS_W;

  // transaction kinds
  localparam logic KIND_UPDATE = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  typedef struct packed {
    logic                  written;
    logic [VALUE_BITS-1:0] value;
  } entry_t;

  localparam entry_t ENTRY_EMPTY = '{written: 1'b0, value: '1};

endpackage

### hdl/rmt_mem.sv
// node store: one write port, two read ports, registered read data
module rmt_mem (
  input  logic                       clk,
  input  logic                       we,
  input  logic [rmt_pkg::NODE_W-1:0] waddr,
  input  rmt_pkg::entry_t            wdata,
  input  logic                       re,
  input  logic [rmt_pkg::NODE_W-1:0] raddr_a,
  input  logic [rmt_pkg::NODE_W-1:0] raddr_b,
  output rmt_pkg::entry_t            rdata_a,
  output rmt_pkg::entry_t            rdata_b
);

  rmt_pkg::entry_t store [rmt_pkg::NODES];

  always_ff @(posedge clk) begin
    if (we) begin
      store[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= store[raddr_a];
      rdata_b <= store[raddr_b];
    end
  end

endmodule

### hdl/rmt_merge.sv
// shared merge unit: smaller value, written flags combined
module rmt_merge (
  input  rmt_pkg::entry_t a,
  input  rmt_pkg::entry_t b,
  output rmt_pkg::entry_t y
);

  always_comb begin
    y.value   = (b.value < a.value) ? b.value : a.value;
    y.written = a.written | b.written;
  end

endmodule

### hdl/range_min_tree_top.sv
// Range-minimum tree over rmt_pkg::LEAVES positions.
//
// Input channel: a transaction is taken on a rising edge with start high
// and busy low. kind selects an update (lower the value at
// update_position to the smaller of old and update_value) or a query
// (minimum over query_low..query_high, query_high clamped to the last
// leaf). Updates give no result; an update past the last leaf is dropped.
//
// Result channel: done is high for exactly one cycle with min_value and
// found valid; the receiver cannot hold it off. An empty range returns all
// ones with found clear.
//
// Timing: an update walks leaf to root, one level a cycle, each sibling read
// issued as the node beside it is written; busy stays high until the root is
// written, and no new transaction is taken before. A query merges, per level,
// the left and then the right boundary node on the merge unit (both boundary
// nodes read at once on the two read ports); an empty range goes straight to
// the result, and busy drops after the result strobe.
//
// Reset: rst (synchronous) starts a clearing pass, one node a cycle, that
// writes every node empty; busy stays high until the pass ends.
module range_min_tree_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic                           kind,
  input  logic [rmt_pkg::POS_W-1:0]      update_position,
  input  logic [rmt_pkg::VAL_PORT_W-1:0] update_value,
  input  logic [rmt_pkg::POS_W-1:0]      query_low,
  input  logic [rmt_pkg::POS_W-1:0]      query_high,
  output logic                           done,
  output logic [rmt_pkg::VAL_PORT_W-1:0] min_value,
  output logic                           found
);

  localparam int NODE_W = rmt_pkg::NODE_W;
  localparam int R_W    = rmt_pkg::R_W;
  localparam int WIDE_W = rmt_pkg::WIDE_W;
  localparam logic [WIDE_W-1:0] LEAVES_W  = WIDE_W'(rmt_pkg::LEAVES);
  localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(rmt_pkg::NODES - 1);
  localparam logic [NODE_W-1:0] ROOT      = NODE_W'(1);

  typedef enum logic [7:0] {
    S_CLEAR   = 8'b0000_0001,
    S_IDLE    = 8'b0000_0010,
    S_U_LEAF  = 8'b0000_0100,
    S_U_UP    = 8'b0000_1000,
    S_Q_ISSUE = 8'b0001_0000,
    S_Q_MRG_L = 8'b0010_0000,
    S_Q_MRG_R = 8'b0100_0000,
    S_Q_DONE  = 8'b1000_0000
  } state_t;

  // control registers
  state_t                state, state_next;
  logic [NODE_W-1:0]     clr_cnt, clr_cnt_next;

  // working registers
  logic [NODE_W-1:0]                 node, node_next;   // update path
  logic [NODE_W-1:0]                 l, l_next;         // query left bound
  logic [R_W-1:0]                    r, r_next;         // query right bound (excl.)
  logic                              take_l, take_l_next;
  logic                              take_r, take_r_next;
  logic [rmt_pkg::VALUE_BITS-1:0]    val, val_next;
  rmt_pkg::entry_t                   acc, acc_next;

  // memory and merge unit hookup
  logic              mem_we, mem_re;
  logic [NODE_W-1:0] mem_waddr, rd_addr_a, rd_addr_b;
  rmt_pkg::entry_t   mem_wdata, rd_data_a, rd_data_b;
  rmt_pkg::entry_t   op_a, op_b, merged;
  logic              do_issue;

  // widened input fields
  logic [WIDE_W-1:0] pos_w, lo_w, hi_w, hi_c;

  rmt_mem u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .re      (mem_re),
    .raddr_a (rd_addr_a),
    .raddr_b (rd_addr_b),
    .rdata_a (rd_data_a),
    .rdata_b (rd_data_b)
  );

  rmt_merge u_merge (
    .a (op_a),
    .b (op_b),
    .y (merged)
  );

  assign pos_w = WIDE_W'(update_position);
  assign lo_w  = WIDE_W'(query_low);
  assign hi_w  = WIDE_W'(query_high);
  assign hi_c  = (hi_w >= LEAVES_W) ? (LEAVES_W - WIDE_W'(1)) : hi_w;

  always_comb begin
    state_next  = state;
    clr_cnt_next = clr_cnt;
    node_next   = node;
    l_next      = l;
    r_next      = r;
    take_l_next = take_l;
    take_r_next = take_r;
    val_next    = val;
    acc_next    = acc;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = node;
    mem_wdata   = merged;
    rd_addr_a   = l;
    rd_addr_b   = NODE_W'(r - R_W'(1));
    op_a        = acc;
    op_b        = rd_data_b;
    do_issue    = 1'b0;

    unique case (state)
      S_CLEAR: begin
        // write every node back to empty
        mem_we    = 1'b1;
        mem_waddr = clr_cnt;
        mem_wdata = rmt_pkg::ENTRY_EMPTY;
        if (clr_cnt == LAST_NODE) begin
          state_next = S_IDLE;
        end else begin
          clr_cnt_next = clr_cnt + NODE_W'(1);
        end
      end
      S_IDLE: begin
        if (start) begin
          if (kind == rmt_pkg::KIND_UPDATE) begin
            if (pos_w < LEAVES_W) begin
              node_next  = NODE_W'(pos_w + LEAVES_W);
              rd_addr_a  = NODE_W'(pos_w + LEAVES_W);
              mem_re     = 1'b1;
              val_next   = rmt_pkg::VALUE_BITS'(update_value);
              state_next = S_U_LEAF;
            end
          end else begin
            acc_next = rmt_pkg::ENTRY_EMPTY;
            if ((lo_w < LEAVES_W) && (lo_w <= hi_c)) begin
              l_next     = NODE_W'(lo_w + LEAVES_W);
              r_next     = R_W'(hi_c + LEAVES_W + WIDE_W'(1));
              state_next = S_Q_ISSUE;
            end else begin
              state_next = S_Q_DONE;
            end
          end
        end
      end
      S_U_LEAF: begin
        // leaf takes the smaller value and is marked written
        op_a       = rd_data_a;
        op_b       = '{written: 1'b1, value: val};
        mem_we     = 1'b1;
        mem_waddr  = node;
        mem_wdata  = merged;
        acc_next   = merged;
        rd_addr_b  = node ^ NODE_W'(1);
        mem_re     = 1'b1;
        node_next  = node >> 1;
        state_next = S_U_UP;
      end
      S_U_UP: begin
        // parent = merge of the child just written and its sibling
        op_a      = acc;
        op_b      = rd_data_b;
        mem_we    = 1'b1;
        mem_waddr = node;
        mem_wdata = merged;
        acc_next  = merged;
        if (node == ROOT) begin
          state_next = S_IDLE;
        end else begin
          rd_addr_b = node ^ NODE_W'(1);
          mem_re    = 1'b1;
          node_next = node >> 1;
        end
      end
      S_Q_ISSUE: begin
        do_issue = 1'b1;
      end
      S_Q_MRG_L: begin
        op_a = acc;
        op_b = rd_data_a;
        if (take_l) begin
          acc_next = merged;
        end
        state_next = S_Q_MRG_R;
      end
      S_Q_MRG_R: begin
        op_a = acc;
        op_b = rd_data_b;
        if (take_r) begin
          acc_next = merged;
        end
        do_issue = 1'b1;
      end
      S_Q_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // one tree level of the query: fetch both boundary nodes, step up, or end the walk
    if (do_issue) begin
      if (R_W'(l) < r) begin
        rd_addr_a   = l;
        rd_addr_b   = NODE_W'(r - R_W'(1));
        mem_re      = 1'b1;
        take_l_next = l[0];
        take_r_next = r[0];
        l_next      = NODE_W'((R_W'(l) + R_W'(l[0])) >> 1);
        r_next      = (r - R_W'(r[0])) >> 1;
        state_next  = S_Q_MRG_L;
      end else begin
        state_next = S_Q_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
    end else begin
      state   <= state_next;
      clr_cnt <= clr_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    node   <= node_next;
    l      <= l_next;
    r      <= r_next;
    take_l <= take_l_next;
    take_r <= take_r_next;
    val    <= val_next;
    acc    <= acc_next;
  end

  assign busy      = (state != S_IDLE);
  assign done      = (state == S_Q_DONE);
  assign min_value = rmt_pkg::VAL_PORT_W'(acc.value);
  assign found     = acc.written;

  // done is always low right after the result strobe
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held for more than one cycle");

  // an update transaction produces no result next
  a_update_silent: assert property (@(posedge clk) disable iff (rst)
      (start && !busy && (kind == rmt_pkg::KIND_UPDATE)) |=> !done)
    else $error("result strobe after an update");

  // nothing written in range means the minimum is still empty
  a_unwritten_empty: assert property (@(posedge clk) disable iff (rst)
      (done && !found) |-> (acc.value == rmt_pkg::ENTRY_EMPTY.value))
    else $error("unwritten range returned a non-empty minimum");

  // clearing pass keeps the block busy after reset
  a_clear_busy: assert property (@(posedge clk) rst |=> busy)
    else $error("not busy right after reset");

  // a query walk never points its left bound past its right bound by more than one
  a_bounds: assert property (@(posedge clk) disable iff (rst)
      (state == S_Q_MRG_L) |-> (R_W'(l) <= r + R_W'(1)))
    else $error("query bounds crossed");

endmodule
